[design/tclp_pkg.sv]
// ----------------------------------------------------------------------------
// tclp_pkg
// Shared types and constants of the text command line parser.
// ----------------------------------------------------------------------------
package tclp_pkg;

   // character codes
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_EQUAL = 8'h3D;
   localparam logic [7:0] CHAR_QUERY = 8'h3F;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_DOT   = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_V     = 8'h76;
   localparam logic [7:0] CHAR_I     = 8'h69;
   localparam logic [7:0] CHAR_X     = 8'h78;
   localparam logic [7:0] CHAR_O     = 8'h6F;
   localparam logic [7:0] CHAR_S     = 8'h73;
   localparam logic [7:0] CHAR_H     = 8'h68;
   localparam logic [7:0] CASE_BIT   = 8'h20;

   localparam int ACC_W   = 32;  // integer and fraction accumulators
   localparam int DIV_W   = 34;  // holds 10^10
   localparam int VALUE_W = 49;
   localparam int CODE_W  = 3;
   localparam int POW_IDX_W = 4;

   typedef enum logic [5:0] {
      PH_LETTER = 6'b000001,
      PH_AFTER  = 6'b000010,
      PH_VSTART = 6'b000100,
      PH_INT    = 6'b001000,
      PH_FRAC   = 6'b010000,
      PH_SKIP   = 6'b100000
   } phase_type;

   typedef enum logic [2:0] {
      LT_NONE  = 3'd0,
      LT_V     = 3'd1,
      LT_I     = 3'd2,
      LT_X     = 3'd3,
      LT_O     = 3'd4,
      LT_S     = 3'd5,
      LT_H     = 3'd6,
      LT_OTHER = 3'd7
   } letter_type;

   typedef enum logic [1:0] {
      OC_NONE     = 2'd0,
      OC_EQUAL    = 2'd1,
      OC_ACCEPTED = 2'd2,
      OC_QUERY    = 2'd3
   } outcome_type;

   typedef enum logic [2:0] {
      CMD_NONE       = 3'd0,
      CMD_SET_VOLT   = 3'd1,
      CMD_SET_AMPS   = 3'd2,
      CMD_BIAS_CLEAR = 3'd3,
      CMD_BIAS_SET   = 3'd4
   } command_type;

   typedef enum logic [2:0] {
      RPL_NONE     = 3'd0,
      RPL_HELP     = 3'd1,
      RPL_UNKNOWN  = 3'd2,
      RPL_BAD      = 3'd3,
      RPL_STATE    = 3'd4,
      RPL_CURRENT  = 3'd5,
      RPL_VOLTAGE  = 3'd6,
      RPL_BIAS     = 3'd7
   } reply_type;

   // controller to datapath
   typedef struct packed {
      logic consume;
      logic div_start;
      logic div_step;
      logic load_out;
      logic clear_line;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic line_blank;
      logic need_div;
      logic div_done;
      logic out_free;
   } dp_status_type;

   function automatic logic [DIV_W-1:0] pow10(input logic [POW_IDX_W-1:0] n);
      logic [DIV_W-1:0] p;
      unique case (n)
         4'd1:    p = 34'd10;
         4'd2:    p = 34'd100;
         4'd3:    p = 34'd1000;
         4'd4:    p = 34'd10000;
         4'd5:    p = 34'd100000;
         4'd6:    p = 34'd1000000;
         4'd7:    p = 34'd10000000;
         4'd8:    p = 34'd100000000;
         4'd9:    p = 34'd1000000000;
         4'd10:   p = 34'd10000000000;
         default: p = 34'd1;
      endcase
      return p;
   endfunction

endpackage

[design/tclp_if.sv]
// ----------------------------------------------------------------------------
// tclp channel interfaces
// Valid/ready channels for line bytes in and parsed results out.
// ----------------------------------------------------------------------------
interface tclp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface tclp_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         command;
   logic signed [48:0] value_q16;
   logic [2:0]         reply_kind;

   modport source (output valid, output command, output value_q16, output reply_kind,
                   input ready);
   modport sink   (input valid, input command, input value_q16, input reply_kind,
                   output ready);
endinterface

[design/tclp_datapath.sv]
// ----------------------------------------------------------------------------
// tclp_datapath
// Byte parser state, fraction divider and result register.
// ----------------------------------------------------------------------------
module tclp_datapath #(
   parameter int MAX_DIGITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tclp_pkg::ctrl_cmd_type            cmd,
   output tclp_pkg::dp_status_type           status,
   input  logic [7:0]                        data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [tclp_pkg::CODE_W-1:0]       rsp_command,
   output logic signed [tclp_pkg::VALUE_W-1:0] rsp_value_q16,
   output logic [tclp_pkg::CODE_W-1:0]       rsp_reply_kind
);

   localparam int CNT_W = $clog2(MAX_DIGITS + 1);
   localparam int DVD_W = tclp_pkg::ACC_W + FRAC_BITS;
   localparam int STEP_W = $clog2(DVD_W);
   localparam int RW = tclp_pkg::DIV_W;

   // parse state
   tclp_pkg::phase_type   phase_ff, phase_in;
   tclp_pkg::letter_type  letter_ff, letter_in;
   tclp_pkg::outcome_type outcome_ff, outcome_in;
   logic                  neg_ff, neg_in;
   logic [31:0]           int_ff, int_in;
   logic [31:0]           frac_ff, frac_in;
   logic [CNT_W-1:0]      icnt_ff, icnt_in;
   logic [CNT_W-1:0]      fcnt_ff, fcnt_in;

   // divider
   logic [DVD_W-1:0]      quo_ff, quo_in;
   logic [RW-1:0]         rem_ff, rem_in;
   logic [RW-1:0]         dsr_ff, dsr_in;
   logic [STEP_W-1:0]     step_ff, step_in;

   // result register
   logic                  valid_ff, valid_in;
   logic [2:0]            command_ff, command_in;
   logic [tclp_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [2:0]            reply_ff, reply_in;

   logic [7:0]            lower;
   logic                  is_space, is_digit, int_ok, frac_ok;
   logic [31:0]           digit;
   tclp_pkg::letter_type  code;
   logic [RW:0]           rem_sh;
   logic [63:0]           mag, signed_mag;
   logic [DVD_W-1:0]      quo_sel;
   tclp_pkg::command_type res_cmd;
   tclp_pkg::reply_type   res_reply;

   // character classes
   always_comb begin
      lower    = data_byte | tclp_pkg::CASE_BIT;
      is_space = (data_byte == tclp_pkg::CHAR_SPACE) || (data_byte == tclp_pkg::CHAR_TAB) ||
                 (data_byte == tclp_pkg::CHAR_CR) || (data_byte == tclp_pkg::CHAR_LF);
      is_digit = (data_byte >= tclp_pkg::CHAR_ZERO) && (data_byte <= tclp_pkg::CHAR_NINE);
      digit    = 32'(data_byte - tclp_pkg::CHAR_ZERO);
      int_ok   = is_digit && (icnt_ff < CNT_W'(MAX_DIGITS));
      frac_ok  = is_digit && (fcnt_ff < CNT_W'(MAX_DIGITS));
      priority if (lower == tclp_pkg::CHAR_V) code = tclp_pkg::LT_V;
      else if (lower == tclp_pkg::CHAR_I)     code = tclp_pkg::LT_I;
      else if (lower == tclp_pkg::CHAR_X)     code = tclp_pkg::LT_X;
      else if (lower == tclp_pkg::CHAR_O)     code = tclp_pkg::LT_O;
      else if (lower == tclp_pkg::CHAR_S)     code = tclp_pkg::LT_S;
      else if (lower == tclp_pkg::CHAR_H)     code = tclp_pkg::LT_H;
      else                                    code = tclp_pkg::LT_OTHER;
   end

   // parse state next values
   always_comb begin
      phase_in   = phase_ff;
      letter_in  = letter_ff;
      outcome_in = outcome_ff;
      neg_in     = neg_ff;
      int_in     = int_ff;
      frac_in    = frac_ff;
      icnt_in    = icnt_ff;
      fcnt_in    = fcnt_ff;
      priority if (cmd.clear_line) begin
         phase_in   = tclp_pkg::PH_LETTER;
         letter_in  = tclp_pkg::LT_NONE;
         outcome_in = tclp_pkg::OC_NONE;
         neg_in     = 1'b0;
         int_in     = '0;
         frac_in    = '0;
         icnt_in    = '0;
         fcnt_in    = '0;
      end else if (cmd.consume) begin
         unique case (phase_ff)
            tclp_pkg::PH_LETTER: begin
               if (!is_space) begin
                  letter_in = code;
                  phase_in  = (code == tclp_pkg::LT_H || code == tclp_pkg::LT_OTHER) ?
                              tclp_pkg::PH_SKIP : tclp_pkg::PH_AFTER;
               end
            end
            tclp_pkg::PH_AFTER: begin
               priority if (data_byte == tclp_pkg::CHAR_EQUAL) begin
                  outcome_in = tclp_pkg::OC_EQUAL;
                  phase_in   = tclp_pkg::PH_VSTART;
               end else if (data_byte == tclp_pkg::CHAR_QUERY) begin
                  outcome_in = tclp_pkg::OC_QUERY;
                  phase_in   = tclp_pkg::PH_SKIP;
               end else begin
                  phase_in = tclp_pkg::PH_SKIP;
               end
            end
            tclp_pkg::PH_VSTART, tclp_pkg::PH_INT: begin
               phase_in = tclp_pkg::PH_INT;
               priority if (phase_ff == tclp_pkg::PH_VSTART &&
                            data_byte == tclp_pkg::CHAR_PLUS) begin
                  outcome_in = tclp_pkg::OC_ACCEPTED;
               end else if (phase_ff == tclp_pkg::PH_VSTART &&
                            data_byte == tclp_pkg::CHAR_MINUS) begin
                  outcome_in = tclp_pkg::OC_ACCEPTED;
                  neg_in     = 1'b1;
               end else if (int_ok) begin
                  int_in     = {int_ff[28:0], 3'b000} + {int_ff[30:0], 1'b0} + digit;
                  icnt_in    = icnt_ff + CNT_W'(1);
                  outcome_in = tclp_pkg::OC_ACCEPTED;
               end else if (data_byte == tclp_pkg::CHAR_DOT) begin
                  outcome_in = tclp_pkg::OC_ACCEPTED;
                  phase_in   = tclp_pkg::PH_FRAC;
               end else begin
                  phase_in = tclp_pkg::PH_SKIP;
               end
            end
            tclp_pkg::PH_FRAC: begin
               if (frac_ok) begin
                  frac_in = {frac_ff[28:0], 3'b000} + {frac_ff[30:0], 1'b0} + digit;
                  fcnt_in = fcnt_ff + CNT_W'(1);
               end else begin
                  phase_in = tclp_pkg::PH_SKIP;
               end
            end
            tclp_pkg::PH_SKIP: ;
            default: phase_in = tclp_pkg::PH_SKIP;
         endcase
      end else begin
         // no byte this cycle, state holds
         phase_in = phase_ff;
      end
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      step_in = step_ff;
      rem_sh  = {rem_ff, quo_ff[DVD_W-1]};
      if (cmd.div_start) begin
         quo_in  = {frac_ff, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         dsr_in  = tclp_pkg::pow10(tclp_pkg::POW_IDX_W'(fcnt_ff));
         step_in = '0;
      end else if (cmd.div_step) begin
         step_in = step_ff + STEP_W'(1);
         if (rem_sh >= {1'b0, dsr_ff}) begin
            rem_in = RW'(rem_sh - {1'b0, dsr_ff});
            quo_in = {quo_ff[DVD_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[RW-1:0];
            quo_in = {quo_ff[DVD_W-2:0], 1'b0};
         end
      end
   end

   // result fields from the finished line
   always_comb begin
      res_cmd   = tclp_pkg::CMD_NONE;
      res_reply = tclp_pkg::RPL_UNKNOWN;
      unique case (letter_ff)
         tclp_pkg::LT_V, tclp_pkg::LT_I: begin
            unique case (outcome_ff)
               tclp_pkg::OC_ACCEPTED: begin
                  res_cmd   = (letter_ff == tclp_pkg::LT_V) ? tclp_pkg::CMD_SET_VOLT :
                                                              tclp_pkg::CMD_SET_AMPS;
                  res_reply = (letter_ff == tclp_pkg::LT_V) ? tclp_pkg::RPL_VOLTAGE :
                                                              tclp_pkg::RPL_CURRENT;
               end
               tclp_pkg::OC_QUERY:
                  res_reply = (letter_ff == tclp_pkg::LT_V) ? tclp_pkg::RPL_VOLTAGE :
                                                              tclp_pkg::RPL_CURRENT;
               tclp_pkg::OC_EQUAL: res_reply = tclp_pkg::RPL_BAD;
               default:            res_reply = tclp_pkg::RPL_UNKNOWN;
            endcase
         end
         tclp_pkg::LT_X, tclp_pkg::LT_O: begin
            res_cmd   = (letter_ff == tclp_pkg::LT_X) ? tclp_pkg::CMD_BIAS_CLEAR :
                                                        tclp_pkg::CMD_BIAS_SET;
            res_reply = (outcome_ff == tclp_pkg::OC_EQUAL) ? tclp_pkg::RPL_BAD :
                                                             tclp_pkg::RPL_BIAS;
         end
         tclp_pkg::LT_S:
            res_reply = (outcome_ff == tclp_pkg::OC_EQUAL) ? tclp_pkg::RPL_BAD :
                                                             tclp_pkg::RPL_STATE;
         tclp_pkg::LT_H: res_reply = tclp_pkg::RPL_HELP;
         default:        res_reply = tclp_pkg::RPL_UNKNOWN;
      endcase
   end

   // fixed point value: integer part plus rounded-down fraction, then sign
   always_comb begin
      quo_sel    = status.need_div ? quo_ff : '0;
      mag        = (64'(int_ff) << FRAC_BITS) + 64'(quo_sel);
      signed_mag = neg_ff ? (64'd0 - mag) : mag;
   end

   // result register
   always_comb begin
      valid_in   = valid_ff;
      command_in = command_ff;
      value_in   = value_ff;
      reply_in   = reply_ff;
      priority if (cmd.load_out) begin
         valid_in   = 1'b1;
         command_in = res_cmd;
         reply_in   = res_reply;
         value_in   = (res_cmd == tclp_pkg::CMD_SET_VOLT || res_cmd == tclp_pkg::CMD_SET_AMPS) ?
                      signed_mag[tclp_pkg::VALUE_W-1:0] : '0;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         // result waits for the receiver
         valid_in = valid_ff;
      end
   end

   always_comb begin
      status.line_blank = (phase_ff == tclp_pkg::PH_LETTER);
      status.need_div   = (letter_ff == tclp_pkg::LT_V || letter_ff == tclp_pkg::LT_I) &&
                          (outcome_ff == tclp_pkg::OC_ACCEPTED) && (fcnt_ff != '0);
      status.div_done   = (step_ff == STEP_W'(DVD_W - 1));
      status.out_free   = !valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= tclp_pkg::PH_LETTER;
         letter_ff  <= tclp_pkg::LT_NONE;
         outcome_ff <= tclp_pkg::OC_NONE;
         neg_ff     <= 1'b0;
         int_ff     <= '0;
         frac_ff    <= '0;
         icnt_ff    <= '0;
         fcnt_ff    <= '0;
         step_ff    <= '0;
         valid_ff   <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         letter_ff  <= letter_in;
         outcome_ff <= outcome_in;
         neg_ff     <= neg_in;
         int_ff     <= int_in;
         frac_ff    <= frac_in;
         icnt_ff    <= icnt_in;
         fcnt_ff    <= fcnt_in;
         step_ff    <= step_in;
         valid_ff   <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      dsr_ff     <= dsr_in;
      command_ff <= command_in;
      value_ff   <= value_in;
      reply_ff   <= reply_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_command    = command_ff;
   assign rsp_value_q16  = signed'(value_ff);
   assign rsp_reply_kind = reply_ff;

endmodule

[design/tclp_controller.sv]
// ----------------------------------------------------------------------------
// tclp_controller
// Sequences byte intake, line-end evaluation, division and result load.
// ----------------------------------------------------------------------------
module tclp_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last,
   output logic                    req_ready,
   input  tclp_pkg::dp_status_type status,
   output tclp_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_ACCEPT = 4'b0001,
      ST_END    = 4'b0010,
      ST_DIV    = 4'b0100,
      ST_LOAD   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_ACCEPT: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.consume = 1'b1;
               if (req_last) state_in = ST_END;
            end
         end
         ST_END: begin
            priority if (status.line_blank) begin
               cmd.clear_line = 1'b1;
               state_in       = ST_ACCEPT;
            end else if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) state_in = ST_LOAD;
         end
         ST_LOAD: begin
            if (status.out_free) begin
               cmd.load_out   = 1'b1;
               cmd.clear_line = 1'b1;
               state_in       = ST_ACCEPT;
            end
         end
         default: state_in = ST_ACCEPT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_ACCEPT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[design/text_command_line_parser_top.sv]
// ----------------------------------------------------------------------------
// text_command_line_parser_top
// Parses one command line per result: letter, optional signed Q32.FRAC value.
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one ascii byte per transaction plus last_byte, which ends
//   the line. bytes are taken one per cycle while no line end is in progress.
//   rsp_chan carries at most one transaction per line: command, value_q16 and
//   reply_kind. a line of whitespace only gives no transaction.
// line end
//   after the last byte the block evaluates the line in ST_END, then runs the
//   restoring divider over a FRAC_BITS+32 bit quotient in ST_DIV when fraction
//   digits were given, then loads the result register in ST_LOAD once the
//   output register is free. req_ready is low from the last byte until that
//   load, so a line costs its length in bytes plus that window.
// reset
//   synchronous reset clears the parse state and empties the result register.
// stall
//   a waiting result stays in the output register while the next line's bytes
//   keep flowing; only a second line end waits until the result is taken.
// ----------------------------------------------------------------------------
module text_command_line_parser_top #(
   parameter int MAX_DIGITS = 10,
   parameter int FRAC_BITS  = 16
) (
   input logic       clock,
   input logic       reset,
   tclp_req_if.sink   req_chan,
   tclp_rsp_if.source rsp_chan
);

   tclp_pkg::ctrl_cmd_type  cmd;    // controller commands
   tclp_pkg::dp_status_type status; // datapath status

   // sequencing of intake, division and result load
   tclp_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_last  (req_chan.last_byte),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // parse registers, fraction divider and output register
   tclp_datapath #(
      .MAX_DIGITS (MAX_DIGITS),
      .FRAC_BITS  (FRAC_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .data_byte      (req_chan.data_byte),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_command    (rsp_chan.command),
      .rsp_value_q16  (rsp_chan.value_q16),
      .rsp_reply_kind (rsp_chan.reply_kind)
   );

endmodule
